@@ rtl/core/vdci_pkg.sv @@
package vdci_pkg;

  localparam int SAMPLE_W = 24;
  localparam int DELAY_W  = 28;
  localparam int SPM_W    = 24;
  localparam int FRAC_W   = 16;
  localparam int DPROD_W  = DELAY_W + SPM_W;
  localparam int DQ_W     = DPROD_W - FRAC_W;

  localparam logic [SPM_W-1:0] SPM_RESET = 24'd3145728;
  localparam logic [DQ_W-1:0]  MIN_Q     = 36'd65537;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic signed [SAMPLE_W-1:0] c;
    logic signed [SAMPLE_W-1:0] d;
    logic [FRAC_W-1:0]          frac;
  } job_t;

endpackage

@@ rtl/core/vdci_if.sv @@
interface vdci_in_if
  import vdci_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [DELAY_W-1:0]         delay_ms;

  modport source (output valid, output sample_in, output delay_ms, input ready);
  modport sink (input valid, input sample_in, input delay_ms, output ready);
endinterface

interface vdci_out_if
  import vdci_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface vdci_cfg_if
  import vdci_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [SPM_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/variable_delay_cubic_interp.sv @@
// One item at a time: the next item is accepted only in idle, once the last
// result is in the output register; the single-port line memory (one write
// and four tap reads per item) and the shared multiplier set the pace.
// A pending result in the output register does not block the next accept.
// Reset (synchronous, active high) empties the line through a fill count,
// zeroes the write pointer and loads samples_per_ms with 48.0.
module variable_delay_cubic_interp
  import vdci_pkg::*;
#(
  parameter int LINE_DEPTH = 65536
) (
  input logic         clk,
  input logic         rst,
  vdci_cfg_if.sink    cfg,
  vdci_in_if.sink     din,
  vdci_out_if.source  dout
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [DQ_W-1:0] MAX_Q     = DQ_W'(LINE_DEPTH - 4) << FRAC_W;
  localparam logic [AW-1:0]   LAST_ADDR = AW'(LINE_DEPTH - 1);
  localparam logic [CW-1:0]   FULL_CNT  = CW'(LINE_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_WRITE  = 9'b000000010,
    S_CLAMP  = 9'b000000100,
    S_ADDR   = 9'b000001000,
    S_READ   = 9'b000010000,
    S_LAST   = 9'b000100000,
    S_CALC   = 9'b001000000,
    S_WAIT   = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [SPM_W-1:0] spm;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [DELAY_W-1:0] dms_q;
  logic [DPROD_W-1:0] dprod;
  logic [DQ_W-1:0] dq, dq_clamped, dqc;
  logic [AW-1:0] whole, base, wp, rd_addr, back;
  logic [CW-1:0] cnt;
  logic [FRAC_W-1:0] frac_q;
  logic [1:0] k, rd_k;
  logic rd_pend, rd_ok;
  logic signed [SAMPLE_W-1:0] taps [4];

  logic mem_we;
  logic [AW-1:0] mem_addr;
  logic [SAMPLE_W-1:0] mem_rdata;

  logic start, done;
  job_t job;
  logic signed [SAMPLE_W-1:0] result;

  logic out_valid;
  logic signed [SAMPLE_W-1:0] out_data;
  logic out_load;

  assign cfg.ready       = 1'b1;
  assign din.ready       = (state == S_IDLE);
  assign dout.valid      = out_valid;
  assign dout.sample_out = out_data;

  assign mem_we   = (state == S_WRITE);
  assign mem_addr = mem_we ? wp : rd_addr;

  vdci_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (sample_q),
    .rdata (mem_rdata)
  );

  assign dq = dprod[FRAC_W +: DQ_W];
  assign dq_clamped = (dq < MIN_Q) ? MIN_Q : ((dq > MAX_Q) ? MAX_Q : dq);
  assign whole = dqc[FRAC_W +: AW];
  assign base  = (wp >= whole) ? (wp - whole)
                               : AW'({1'b0, wp} + FULL_CNT - {1'b0, whole});

  assign start    = (state == S_CALC);
  assign job.a    = taps[0];
  assign job.b    = taps[1];
  assign job.c    = taps[2];
  assign job.d    = taps[3];
  assign job.frac = frac_q;

  vdci_interp u_interp (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .job    (job),
    .done   (done),
    .result (result)
  );

  assign out_load = (state == S_FINISH) && (!out_valid || dout.ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (din.valid) state_next = S_WRITE;
      S_WRITE:  state_next = S_CLAMP;
      S_CLAMP:  state_next = S_ADDR;
      S_ADDR:   state_next = S_READ;
      S_READ:   if (k == 2'd3) state_next = S_LAST;
      S_LAST:   state_next = S_CALC;
      S_CALC:   state_next = S_WAIT;
      S_WAIT:   if (done) state_next = S_FINISH;
      S_FINISH: if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      spm       <= SPM_RESET;
      wp        <= '0;
      cnt       <= '0;
      k         <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == S_READ);
      if (cfg.valid) begin
        spm <= cfg.data;
      end
      if (state == S_WRITE) begin
        wp <= (wp == LAST_ADDR) ? '0 : wp + 1'b1;
        if (cnt != FULL_CNT) begin
          cnt <= cnt + 1'b1;
        end
      end
      if (state == S_READ) begin
        k <= k + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        sample_q <= din.sample_in;
        dms_q    <= din.delay_ms;
      end
      S_WRITE: dprod <= DPROD_W'(dms_q) * DPROD_W'(spm);
      S_CLAMP: dqc <= dq_clamped;
      S_ADDR: begin
        rd_addr <= base;
        back    <= whole;
        frac_q  <= dqc[FRAC_W-1:0];
      end
      S_READ: begin
        rd_addr <= (rd_addr == '0) ? LAST_ADDR : rd_addr - 1'b1;
        back    <= back + 1'b1;
        rd_k    <= k;
        rd_ok   <= ({1'b0, back} <= cnt);
      end
      default: begin
      end
    endcase
    // taps older than the first write read as zero
    if (rd_pend) begin
      taps[rd_k] <= rd_ok ? $signed(mem_rdata) : '0;
    end
    if (out_load) begin
      out_data <= result;
    end
  end

  a_accept_writes: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready) |=> mem_we)
    else $error("accepted item not written to line");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= FULL_CNT)
    else $error("fill count beyond line depth");

  a_whole_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADDR) |-> (whole != '0) && (whole <= AW'(LINE_DEPTH - 4)))
    else $error("tap offset out of range");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result shown without finished item");

endmodule

@@ rtl/core/vdci_ram.sv @@
module vdci_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/core/vdci_interp.sv @@
module vdci_interp
  import vdci_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  job_t                       job,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] result
);

  localparam logic signed [18:0] SIXTH   = 19'sd174763;
  localparam logic signed [63:0] ROUND   = 64'sd2147483648;
  localparam logic signed [29:0] OUT_MAX = 30'sd8388607;
  localparam logic signed [29:0] OUT_MIN = -30'sd8388608;

  typedef enum logic [13:0] {
    I_IDLE = 14'b00000000000001,
    I_M1   = 14'b00000000000010,
    I_P    = 14'b00000000000100,
    I_M2   = 14'b00000000001000,
    I_M3   = 14'b00000000010000,
    I_Q    = 14'b00000000100000,
    I_M4   = 14'b00000001000000,
    I_M5   = 14'b00000010000000,
    I_R    = 14'b00000100000000,
    I_N    = 14'b00001000000000,
    I_M6   = 14'b00010000000000,
    I_M7   = 14'b00100000000000,
    I_S    = 14'b01000000000000,
    I_OUT  = 14'b10000000000000
  } ist_t;

  ist_t st, st_next;

  logic signed [26:0] a27, b27, c27, d27, m27, x27, e27;
  logic signed [26:0] x_q, e_q;
  logic signed [24:0] m_q;
  logic signed [SAMPLE_W-1:0] b_q;
  logic [FRAC_W-1:0] frac_q;
  logic [16:0] w_q;

  logic signed [27:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [46:0] prod;
  logic signed [63:0] prod_x, acc, sum_w, t_q;
  logic signed [45:0] p_q, q_q, r_q, n_q;
  logic signed [29:0] res;

  assign a27 = {{3{job.a[SAMPLE_W-1]}}, job.a};
  assign b27 = {{3{job.b[SAMPLE_W-1]}}, job.b};
  assign c27 = {{3{job.c[SAMPLE_W-1]}}, job.c};
  assign d27 = {{3{job.d[SAMPLE_W-1]}}, job.d};
  assign m27 = c27 - b27;
  assign x27 = d27 - a27 - (m27 <<< 1) - m27;
  assign e27 = d27 + (a27 <<< 1) - (b27 <<< 1) - b27;

  // shared multiplier: wide operands go through as a 22-bit low and a high chunk
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st)
      I_M1: begin
        mul_a = {x_q[26], x_q};
        mul_b = {3'b0, frac_q};
      end
      I_M2: begin
        mul_a = {6'b0, p_q[21:0]};
        mul_b = {2'b0, w_q};
      end
      I_M3: begin
        mul_a = {{4{p_q[45]}}, p_q[45:22]};
        mul_b = {2'b0, w_q};
      end
      I_M4: begin
        mul_a = {6'b0, q_q[21:0]};
        mul_b = SIXTH;
      end
      I_M5: begin
        mul_a = {{4{q_q[45]}}, q_q[45:22]};
        mul_b = SIXTH;
      end
      I_M6: begin
        mul_a = {6'b0, n_q[21:0]};
        mul_b = {3'b0, frac_q};
      end
      I_M7: begin
        mul_a = {{4{n_q[45]}}, n_q[45:22]};
        mul_b = {3'b0, frac_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_x = {{17{prod[46]}}, prod};
  assign sum_w  = acc + (prod_x <<< 22);
  assign res    = {{6{b_q[SAMPLE_W-1]}}, b_q} + 30'(t_q >>> 32);

  always_comb begin
    st_next = st;
    case (st)
      I_IDLE: if (start) st_next = I_M1;
      I_M1:   st_next = I_P;
      I_P:    st_next = I_M2;
      I_M2:   st_next = I_M3;
      I_M3:   st_next = I_Q;
      I_Q:    st_next = I_M4;
      I_M4:   st_next = I_M5;
      I_M5:   st_next = I_R;
      I_R:    st_next = I_N;
      I_N:    st_next = I_M6;
      I_M6:   st_next = I_M7;
      I_M7:   st_next = I_S;
      I_S:    st_next = I_OUT;
      I_OUT:  st_next = I_IDLE;
      default: st_next = I_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= I_IDLE;
      done <= 1'b0;
    end else begin
      st   <= st_next;
      done <= (st == I_OUT);
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (st)
      I_IDLE: begin
        if (start) begin
          x_q    <= x27;
          e_q    <= e27;
          m_q    <= m27[24:0];
          b_q    <= job.b;
          frac_q <= job.frac;
          w_q    <= 17'h10000 - {1'b0, job.frac};
        end
      end
      I_P:  p_q <= prod[45:0] + {{3{e_q[26]}}, e_q, 16'b0};
      I_M3: acc <= prod_x;
      I_Q:  q_q <= sum_w[61:16];
      I_M5: acc <= prod_x;
      I_R:  r_q <= {{2{sum_w[63]}}, sum_w[63:20]};
      I_N:  n_q <= {{5{m_q[24]}}, m_q, 16'b0} - r_q;
      I_M7: acc <= prod_x;
      I_S:  t_q <= sum_w + ROUND;
      I_OUT: begin
        if (res > OUT_MAX) begin
          result <= OUT_MAX[SAMPLE_W-1:0];
        end else if (res < OUT_MIN) begin
          result <= OUT_MIN[SAMPLE_W-1:0];
        end else begin
          result <= res[SAMPLE_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (st == I_IDLE))
    else $error("interp started while busy");

  a_done_after_out: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(st == I_OUT))
    else $error("done without final step");

endmodule
